// ===== design/bbf_pkg.sv =====
// shared widths, register indexes and defaults for the bollinger band filter
`timescale 1ns / 1ps
package bbf_pkg;

  localparam int DEF_MAX_WINDOW  = 256;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int WIN_W   = 9;   // window_length register
  localparam int MULT_W  = 16;  // band_multiplier, unsigned Q4.12
  localparam int WARM_W  = 16;  // warmup_length register
  localparam int IDX_W   = 16;  // sample index, saturating
  localparam int SUM_W   = 32;  // running sum, wraps
  localparam int SQ_W    = 56;  // running square sum, wraps
  localparam int ROOT_W  = SQ_W / 2;
  localparam int FRAC_SH = 12;  // multiplier fraction bits
  localparam int CFG_W   = 16;  // widest register
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_MULT   = 2'd1,
    CFG_WARMUP = 2'd2
  } cfg_idx_e;

endpackage

// ===== design/bbf_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bbf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bbf_div
  import bbf_pkg::*;
#(
  parameter int N = SUM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [N-1:0]     dividend_i,
  input  logic [WIN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [N-1:0]     quot_o
);

  localparam int CW = $clog2(N + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [WIN_W-1:0] rem_q;
  logic [N-1:0]  acc_q;
  logic [WIN_W:0] rem_sh;
  logic           ge;

  // shift the next dividend bit into the partial remainder
  assign rem_sh = {rem_q, acc_q[N-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(N);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      acc_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? WIN_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[WIN_W-1:0];
      acc_q <= {acc_q[N-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;

endmodule

// ===== design/bbf_sqrt.sv =====
// digit-by-digit floor square root, two radicand bits per cycle
`timescale 1ns / 1ps
module bbf_sqrt
  import bbf_pkg::*;
#(
  parameter int W = SQ_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     rad_i,
  output logic             busy_o,
  output logic [W/2-1:0]   root_o
);

  localparam int RW = W / 2;
  localparam int CW = $clog2(RW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rad_q;
  logic [RW:0]   rem_q;
  logic [RW-1:0] root_q;
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          ge;

  assign rem_sh = {rem_q, rad_q[W-1:W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[W-3:0], 2'b00};
      rem_q  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== design/bollinger_band_filter.sv =====
// bollinger band filter top level: window store, running sums and band sequencer
`timescale 1ns / 1ps
// One request in, one result out. Each sample updates a running sum and sum of squares
// over a ring store of the last window_length samples, then the mean (sum / period) and
// the mean square (sum2 / period) come from two bit-serial dividers run side by side,
// the deviation from a bit-serial square root, and the bands from mean +/- multiplier
// times deviation, saturated to the sample range. A request passes from accept to result
// through store read, sum update and divider start, a wait for the 56-bit square-sum
// divider (the longer of the two), mean, mean square and root start, a wait for the
// square root, and then band product, bands and output load. The next request is
// accepted only after the result is loaded and the sequencer is back in idle, so a new
// request is not taken before the last one is through. Input ready is high only between
// requests; a finished result sits in the output register while the next request is
// already being worked on, and the sequencer waits at the end only if that result has
// not been taken yet. Configuration is taken at any time through the write port and is
// expected to change only while the block is idle.
module bollinger_band_filter
  import bbf_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          sample_valid_i,
  input  logic                          series_start_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] middle_o,
  output logic                          middle_valid_o,
  output logic signed [SAMPLE_BITS-1:0] upper_band_o,
  output logic signed [SAMPLE_BITS-1:0] lower_band_o,
  output logic                          bands_valid_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = $clog2(MAX_WINDOW);
  localparam int EW  = ((PW > WIN_W) ? PW : WIN_W) + 2;  // slot arithmetic width
  localparam int VW  = SQ_W + 2;                          // signed variance width
  localparam int PRW = MULT_W + ROOT_W;                   // band product width
  localparam int BW  = SUM_W + 2;                         // mean and band sum width

  localparam logic signed [BW-1:0] SMAX = BW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [BW-1:0] SMIN = -SMAX - BW'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OLD, ST_UPD, ST_DIVGO, ST_DIV, ST_MEAN, ST_MSQ,
    ST_VAR, ST_ROOT, ST_PROD, ST_BAND, ST_OUT
  } state_e;

  // saturate a wide signed value to the sample range
  function automatic logic [SB-1:0] sat_sample(input logic signed [BW-1:0] v);
    logic signed [BW-1:0] r;
    if (v > SMAX) begin
      r = SMAX;
    end else if (v < SMIN) begin
      r = SMIN;
    end else begin
      r = v;
    end
    return r[SB-1:0];
  endfunction

  // square of a signed sample, taken on its magnitude
  function automatic logic [SQ_W-1:0] sq_mag(input logic signed [SB-1:0] v);
    logic [SB-1:0]   m;
    logic [2*SB-1:0] p;
    m = v[SB-1] ? SB'(-v) : v;
    p = m * m;
    return SQ_W'(p);
  endfunction

  // configuration registers
  logic [WIN_W-1:0]  window_q;
  logic [MULT_W-1:0] mult_q;
  logic [WARM_W-1:0] warm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(20);
      mult_q   <= MULT_W'(8192);
      warm_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
        CFG_MULT:   mult_q   <= cfg_data_i;
        CFG_WARMUP: warm_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q;

  // window state
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]  sum2_q, sum2_d;
  logic [WIN_W-1:0] vcnt_q, vcnt_d;
  logic [IDX_W-1:0] idx_q;
  logic [PW-1:0]    wp_q;

  // per-request datapath
  logic signed [SB-1:0]   x_q;
  logic                   xv_q;
  logic [SQ_W-1:0]        sq_new_q;
  logic [SQ_W-1:0]        sq_old_q;
  logic signed [SB-1:0]   old_q;
  logic                   old_ok_q;
  logic                   mid_ok_q;
  logic                   band_ok_q;
  logic [SB-1:0]          mean_q;
  logic [SQ_W-1:0]        msq_q;
  logic                   var_pos_q;
  logic [PRW-1:0]         prod_q;
  logic [SB-1:0]          up_q;
  logic [SB-1:0]          lo_q;

  // result register
  logic          out_valid_q;
  logic [SB-1:0] middle_q, upper_q, lower_q;
  logic          mid_v_q, band_v_q;

  // period checks
  logic period_ok;
  logic drop_old;
  logic mid_ok_d;
  logic [IDX_W:0] idx_p1;

  assign period_ok = (window_q != '0) && (32'(window_q) <= 32'(MAX_WINDOW));
  assign idx_p1    = {1'b0, idx_q} + 1'b1;
  assign drop_old  = period_ok && ({1'b0, idx_q} >= (IDX_W+1)'(window_q)) && old_ok_q;

  // ring slot of the sample leaving the window
  logic [EW-1:0] wp_e, per_e, slot_e;
  logic [PW-1:0] slot;

  assign wp_e   = EW'(wp_q);
  assign per_e  = EW'(window_q);
  assign slot_e = (wp_e >= per_e) ? (wp_e - per_e) : (wp_e + EW'(MAX_WINDOW) - per_e);
  assign slot   = slot_e[PW-1:0];

  // window store: sample and its valid flag
  logic [SB:0] rd_data;

  bbf_ram #(
    .WIDTH (SB + 1),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPD),
    .waddr_i (wp_q),
    .wdata_i ({xv_q, x_q}),
    .raddr_i (slot),
    .rdata_o (rd_data)
  );

  // sum update, new sample in and oldest sample out
  always_comb begin
    sum_d  = sum_q;
    sum2_d = sum2_q;
    vcnt_d = vcnt_q;
    if (xv_q) begin
      sum_d  = sum_d + SUM_W'(x_q);
      sum2_d = sum2_d + sq_new_q;
      vcnt_d = vcnt_d + 1'b1;
    end
    if (drop_old) begin
      sum_d  = sum_d - SUM_W'(old_q);
      sum2_d = sum2_d - sq_old_q;
      vcnt_d = vcnt_d - 1'b1;
    end
  end

  assign mid_ok_d = period_ok && (idx_p1 >= (IDX_W+1)'(window_q)) && (vcnt_d == window_q)
                    && !(idx_p1 < (IDX_W+1)'(warm_q));

  // mean: divide the magnitude of the sum, then put the sign back
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] qm;
  logic [SQ_W-1:0]  qv;
  logic             dm_busy, dv_busy;
  logic [BW-1:0]    mean_w;

  assign sum_neg = sum_q[SUM_W-1];
  assign sum_mag = sum_neg ? (SUM_W'(0) - sum_q) : sum_q;
  assign mean_w  = sum_neg ? (BW'(0) - BW'(qm)) : BW'(qm);

  bbf_div #(.N(SUM_W)) u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVGO),
    .dividend_i (sum_mag),
    .divisor_i  (window_q),
    .busy_o     (dm_busy),
    .quot_o     (qm)
  );

  bbf_div #(.N(SQ_W)) u_div_sq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVGO),
    .dividend_i (sum2_q),
    .divisor_i  (window_q),
    .busy_o     (dv_busy),
    .quot_o     (qv)
  );

  // variance = mean square - square of mean
  logic signed [VW-1:0] var_w;
  logic [ROOT_W-1:0]    root;
  logic                 sq_busy;

  assign var_w = $signed({2'b00, qv}) - $signed({2'b00, msq_q});

  bbf_sqrt #(.W(SQ_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_VAR),
    .rad_i   (var_w[SQ_W-1:0]),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // band offset, Q.12 product truncated to Q.0
  logic [BW-1:0] dev_off;
  logic [BW-1:0] mean_e;

  assign dev_off = BW'(prod_q >> FRAC_SH);
  assign mean_e  = BW'($signed(mean_q));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sum2_q      <= '0;
      vcnt_q      <= '0;
      idx_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a result leaving while a new one loads is handled in ST_OUT
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            // a new series clears the sums before this sample joins them
            if (series_start_i) begin
              sum_q  <= '0;
              sum2_q <= '0;
              vcnt_q <= '0;
              idx_q  <= '0;
            end
            state_q <= ST_OLD;
          end
        end
        ST_OLD:  state_q <= ST_UPD;
        ST_UPD: begin
          sum_q  <= sum_d;
          sum2_q <= sum2_d;
          vcnt_q <= vcnt_d;
          wp_q   <= (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + 1'b1;
          if (idx_q != '1) begin
            idx_q <= idx_q + 1'b1;
          end
          state_q <= ST_DIVGO;
        end
        ST_DIVGO: state_q <= ST_DIV;
        ST_DIV: begin
          if (!dm_busy && !dv_busy) begin
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: state_q <= ST_MSQ;
        ST_MSQ:  state_q <= ST_VAR;
        ST_VAR:  state_q <= ST_ROOT;
        ST_ROOT: begin
          if (!sq_busy) begin
            state_q <= ST_PROD;
          end
        end
        ST_PROD: state_q <= ST_BAND;
        ST_BAND: state_q <= ST_OUT;
        ST_OUT: begin
          // hold here until the previous result has left
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, loaded by state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        x_q      <= sample_i;
        xv_q     <= sample_valid_i;
        sq_new_q <= sq_mag(sample_i);
      end
      ST_OLD: begin
        old_q    <= $signed(rd_data[SB-1:0]);
        old_ok_q <= rd_data[SB];
        sq_old_q <= sq_mag($signed(rd_data[SB-1:0]));
      end
      ST_UPD: begin
        mid_ok_q  <= mid_ok_d;
        band_ok_q <= mid_ok_d && (window_q >= WIN_W'(2));
      end
      ST_MEAN: mean_q <= sat_sample($signed(mean_w));
      ST_MSQ:  msq_q  <= sq_mag($signed(mean_q));
      ST_VAR:  var_pos_q <= (var_w > 0);
      ST_PROD: prod_q <= var_pos_q ? (PRW'(mult_q) * PRW'(root)) : '0;
      ST_BAND: begin
        up_q <= sat_sample($signed(mean_e + dev_off));
        lo_q <= sat_sample($signed(mean_e - dev_off));
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          mid_v_q  <= mid_ok_q;
          band_v_q <= band_ok_q;
          middle_q <= mid_ok_q ? mean_q : '0;
          upper_q  <= band_ok_q ? up_q : '0;
          lower_q  <= band_ok_q ? lo_q : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign middle_o       = $signed(middle_q);
  assign middle_valid_o = mid_v_q;
  assign upper_band_o   = $signed(upper_q);
  assign lower_band_o   = $signed(lower_q);
  assign bands_valid_o  = band_v_q;

endmodule

// ===== design/bbf_checker.sv =====
// port-level checks for the bollinger band filter and their bind
`timescale 1ns / 1ps
module bbf_props
  import bbf_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] middle_o,
  input logic                          middle_valid_o,
  input logic signed [SAMPLE_BITS-1:0] upper_band_o,
  input logic signed [SAMPLE_BITS-1:0] lower_band_o,
  input logic                          bands_valid_o
);

  // a waiting result holds its middle and upper band values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(middle_o) && $stable(upper_band_o))
    else $error("stalled result changed");

  // bands only with a defined middle line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bands_valid_o |-> middle_valid_o)
    else $error("bands valid without middle");

  // invalid bands read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bands_valid_o |-> upper_band_o == '0 && lower_band_o == '0)
    else $error("invalid bands not zero");

  // lower band never above upper band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bands_valid_o |-> lower_band_o <= upper_band_o)
    else $error("bands crossed");

  // one request at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

endmodule

bind bollinger_band_filter bbf_props #(.SAMPLE_BITS(SAMPLE_BITS)) u_bbf_checker (.*);
